// ===== rtl/serial_multiply_divide_unit_macros.svh =====
// Assertion macros for the serial multiply/divide unit checker.
`ifndef SERIAL_MULTIPLY_DIVIDE_UNIT_MACROS_SVH
`define SERIAL_MULTIPLY_DIVIDE_UNIT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define SMDU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define SMDU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/smdu_pkg.sv =====
// Types and constants for the serial multiply/divide unit.
`timescale 1ns / 1ps
package smdu_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_MUL  = 2'd1;
  localparam logic [1:0] OP_DIV  = 2'd2;

  localparam logic [3:0] MUL_STEPS = 4'd8;
  localparam logic [4:0] DIV_STEPS = 5'd16;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  factor_a;
    logic [7:0]  factor_b_or_divisor;
    logic [15:0] dividend;
  } smdu_req_t;

  typedef struct packed {
    logic [15:0] low_result;
    logic [15:0] high_result;
    logic        busy_res;
  } smdu_rsp_t;

endpackage

// ===== rtl/serial_multiply_divide_unit.sv =====
// Top level of the bit-serial 8x8 multiplier and 16/8 restoring divider.
//
//   channel  | signals                         | moves
//   ---------+---------------------------------+-----------------------------
//   in       | in_valid_i  in_ready_o  in_req_i | one request: tick, start or no-op
//   out      | out_valid_o out_ready_i out_rsp_o| one response per request
//
// One request per cycle while in_ready_o is high; its response is registered and appears in the cycle after acceptance.
// Each tick does one shift-add or compare-subtract step on the state registers while a count is nonzero.
// A multiply needs 8 ticks after its start, a divide 16.
// in_ready_o is low only while the output register holds an untaken response.
// Reset clears the state registers and the output valid flag, but not the response payload.
`timescale 1ns / 1ps
module serial_multiply_divide_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  smdu_pkg::smdu_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output smdu_pkg::smdu_rsp_t out_rsp_o
);
  import smdu_pkg::*;

  logic [15:0] prod_q, prod_d;
  logic [15:0] quot_q, quot_d;
  logic [23:0] shift_q, shift_d;
  logic [3:0]  mul_cnt_q, mul_cnt_d;
  logic [4:0]  div_cnt_q, div_cnt_d;
  logic [23:0] shift_dn;
  logic        out_valid_q;
  smdu_rsp_t   rsp_q;
  logic        accept;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;
  assign shift_dn    = {1'b0, shift_q[23:1]};

  // Multiply and divide counts are never both nonzero.
  always_comb begin
    prod_d    = prod_q;
    quot_d    = quot_q;
    shift_d   = shift_q;
    mul_cnt_d = mul_cnt_q;
    div_cnt_d = div_cnt_q;
    case (in_req_i.opcode)
      OP_TICK: begin
        if (mul_cnt_q != 4'd0) begin
          mul_cnt_d = mul_cnt_q - 4'd1;
          if (quot_q[0]) begin
            prod_d = prod_q + shift_q[15:0];
          end
          quot_d  = {1'b0, quot_q[15:1]};
          shift_d = {shift_q[22:0], 1'b0};
        end else if (div_cnt_q != 5'd0) begin
          div_cnt_d = div_cnt_q - 5'd1;
          shift_d   = shift_dn;
          quot_d    = {quot_q[14:0], 1'b0};
          if ({8'd0, prod_q} >= shift_dn) begin
            prod_d    = prod_q - shift_dn[15:0];
            quot_d[0] = 1'b1;
          end
        end
      end
      OP_MUL: begin
        prod_d    = '0;
        quot_d    = {in_req_i.factor_b_or_divisor, in_req_i.factor_a};
        shift_d   = {16'd0, in_req_i.factor_b_or_divisor};
        mul_cnt_d = MUL_STEPS;
        div_cnt_d = '0;
      end
      OP_DIV: begin
        prod_d    = in_req_i.dividend;
        shift_d   = {in_req_i.factor_b_or_divisor, 16'd0};
        div_cnt_d = DIV_STEPS;
        mul_cnt_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q      <= '0;
      quot_q      <= '0;
      shift_q     <= '0;
      mul_cnt_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        prod_q      <= prod_d;
        quot_q      <= quot_d;
        shift_q     <= shift_d;
        mul_cnt_q   <= mul_cnt_d;
        div_cnt_q   <= div_cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Response payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q.low_result  <= prod_d;
      rsp_q.high_result <= quot_d;
      rsp_q.busy_res    <= (mul_cnt_d != 4'd0) || (div_cnt_d != 5'd0);
    end
  end

endmodule

// ===== rtl/smdu_checker.sv =====
// Port-level checker for the serial multiply/divide unit, with its bind.
`timescale 1ns / 1ps
`include "serial_multiply_divide_unit_macros.svh"
module smdu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input smdu_pkg::smdu_req_t in_req_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input smdu_pkg::smdu_rsp_t out_rsp_o
);
  import smdu_pkg::*;

  `SMDU_ASSERT_ALWAYS(a_ready_tracks_out, !rst_ni || (in_ready_o == (!out_valid_o || out_ready_i)), "in_ready_o does not follow the output register")
  `SMDU_ASSERT(a_rsp_held, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o), "stalled response changed")
  `SMDU_ASSERT(a_mul_start, in_valid_i && in_ready_o && in_req_i.opcode == OP_MUL |=> out_valid_o && out_rsp_o.busy_res && out_rsp_o.low_result == 16'd0, "multiply start response wrong")
  `SMDU_ASSERT(a_div_start, in_valid_i && in_ready_o && in_req_i.opcode == OP_DIV |=> out_valid_o && out_rsp_o.busy_res && out_rsp_o.low_result == $past(in_req_i.dividend), "divide start response wrong")

endmodule

bind serial_multiply_divide_unit smdu_checker u_smdu_checker (.*);

// ===== bench/tb_serial_multiply_divide_unit.sv =====
// Self-checking testbench for the bit-serial multiply/divide unit.
`timescale 1ns / 1ps
module tb_serial_multiply_divide_unit;
  import smdu_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1450;
  localparam int PHASES = 4;

  typedef struct {
    smdu_req_t req;
    bit        typed;
    smdu_rsp_t rsp;
  } table_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  smdu_req_t in_req_i;
  logic      out_valid_o;
  logic      out_ready_i;
  smdu_rsp_t out_rsp_o;

  serial_multiply_divide_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // predictor state
  logic [15:0] acc_q;
  logic [15:0] quo_q;
  logic [23:0] shf_q;
  logic [3:0]  mul_left_q;
  logic [4:0]  div_left_q;

  smdu_rsp_t  register_snapshots[$];
  table_row_t directed_rows[$];
  int         fail_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         sent_items = 0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic smdu_rsp_t advance_muldiv(smdu_req_t req);
    smdu_rsp_t rsp;
    case (req.opcode)
      OP_TICK: begin
        if (mul_left_q != 0) begin
          mul_left_q = mul_left_q - 4'd1;
          if (quo_q[0]) acc_q = acc_q + shf_q[15:0];
          quo_q = quo_q >> 1;
          shf_q = shf_q << 1;
        end
        if (div_left_q != 0) begin
          div_left_q = div_left_q - 5'd1;
          quo_q = quo_q << 1;
          shf_q = shf_q >> 1;
          if ({8'h00, acc_q} >= shf_q) begin
            acc_q = acc_q - shf_q[15:0];
            quo_q[0] = 1'b1;
          end
        end
      end
      OP_MUL: begin
        acc_q = 16'h0000;
        quo_q = {req.factor_b_or_divisor, req.factor_a};
        shf_q = {16'h0000, req.factor_b_or_divisor};
        mul_left_q = MUL_STEPS;
        div_left_q = '0;
      end
      OP_DIV: begin
        acc_q = req.dividend;
        shf_q = {req.factor_b_or_divisor, 16'h0000};
        div_left_q = DIV_STEPS;
        mul_left_q = '0;
      end
      default: ;
    endcase
    rsp.low_result  = acc_q;
    rsp.high_result = quo_q;
    rsp.busy_res    = (mul_left_q != 0) || (div_left_q != 0);
    return rsp;
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_req(input smdu_req_t req, input bit typed, input smdu_rsp_t typed_rsp);
    smdu_rsp_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i   = req;
    do @(posedge clk_i); while (!in_ready_o);
    pred = advance_muldiv(req);
    register_snapshots.push_back(typed ? typed_rsp : pred);
    @(negedge clk_i);
  endtask

  task automatic add_row(input logic [1:0] op, input logic [7:0] a, input logic [7:0] b,
                         input logic [15:0] dvd, input bit typed, input logic [15:0] lo,
                         input logic [15:0] hi, input logic busy);
    table_row_t row;
    row.req = '{opcode: op, factor_a: a, factor_b_or_divisor: b, dividend: dvd};
    row.typed = typed;
    row.rsp = '{low_result: lo, high_result: hi, busy_res: busy};
    directed_rows.push_back(row);
  endtask

  task automatic send_random(input logic [1:0] op);
    smdu_req_t req;
    smdu_rsp_t none;
    none = '0;
    req.opcode = op;
    req.factor_a = pick_byte();
    req.factor_b_or_divisor = pick_byte();
    req.dividend = pick_word();
    if (op == OP_DIV && $urandom_range(0, 9) == 0) req.factor_b_or_divisor = 8'h00;
    sent_items++;
    send_req(req, 1'b0, none);
  endtask

  // start, then ticks that finish, overrun or are cut short; or 1-3 random requests
  task automatic run_sequence();
    int kind;
    int ticks;
    int steps;
    kind = $urandom_range(0, 99);
    if (kind < 90) begin
      steps = (kind < 45) ? 8 : 16;
      send_random((kind < 45) ? OP_MUL : OP_DIV);
      if ($urandom_range(0, 9) < 7) ticks = steps + $urandom_range(0, 2);
      else ticks = $urandom_range(0, steps - 1);
      for (int i = 0; i < ticks; i++) begin
        if ($urandom_range(0, 19) == 0) send_random(OP_UNUSED);
        send_random(OP_TICK);
      end
    end else begin
      for (int i = 0; i < $urandom_range(1, 3); i++) send_random(2'($urandom_range(0, 3)));
    end
  endtask

  always @(posedge clk_i) begin
    smdu_rsp_t exp_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (register_snapshots.size() == 0) begin
        $error("response with no request outstanding");
        fail_count++;
      end else begin
        exp_rsp = register_snapshots.pop_front();
        if (out_rsp_o.low_result !== exp_rsp.low_result) begin
          $error("low_result: expected %h, got %h", exp_rsp.low_result, out_rsp_o.low_result);
          fail_count++;
        end
        if (out_rsp_o.high_result !== exp_rsp.high_result) begin
          $error("high_result: expected %h, got %h", exp_rsp.high_result,
                 out_rsp_o.high_result);
          fail_count++;
        end
        if (out_rsp_o.busy_res !== exp_rsp.busy_res) begin
          $error("busy_res: expected %b, got %b", exp_rsp.busy_res, out_rsp_o.busy_res);
          fail_count++;
        end
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    #2000000;
    $display("serial_multiply_divide_unit verification failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    acc_q = '0;
    quo_q = '0;
    shf_q = '0;
    mul_left_q = '0;
    div_left_q = '0;

    // tick while idle, full-scale multiply, opcode three no-op, divide by zero
    add_row(OP_TICK, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 16'h0000, 16'h0000, 1'b0);
    add_row(OP_MUL, 8'hFF, 8'hFF, 16'h0000, 1'b1, 16'h0000, 16'hFFFF, 1'b1);
    for (int i = 0; i < 7; i++) add_row(OP_TICK, 8'h00, 8'h00, 16'h0000, 1'b0, '0, '0, 1'b0);
    add_row(OP_TICK, 8'h00, 8'h00, 16'h0000, 1'b1, 16'hFE01, 16'h00FF, 1'b0);
    add_row(OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 16'hFE01, 16'h00FF, 1'b0);
    add_row(OP_DIV, 8'h00, 8'h00, 16'hFFFF, 1'b1, 16'hFFFF, 16'h00FF, 1'b1);
    for (int i = 0; i < 15; i++) add_row(OP_TICK, 8'h00, 8'h00, 16'h0000, 1'b0, '0, '0, 1'b0);
    add_row(OP_TICK, 8'h00, 8'h00, 16'h0000, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) send_req(directed_rows[i].req, directed_rows[i].typed,
                                        directed_rows[i].rsp);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      while (sent_items < (ph + 1) * RANDOM_ITEMS / PHASES) run_sequence();
      in_valid_i = 1'b0;
      while (register_snapshots.size() != 0) @(negedge clk_i);
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) $display("serial_multiply_divide_unit verification clean");
    else $display("serial_multiply_divide_unit verification failed");
    $finish;
  end

endmodule
